>>> design/sud_pkg.sv
package sud_pkg;

   localparam int SPHERES_DEF = 16;

   localparam int COORD_W = 32;
   localparam int RAD_W   = 31;
   localparam int CELL_W  = 11;
   localparam int MESH_W  = 24;
   localparam int COUNT_W = 5;
   localparam int CSR_IDX_W = 3;

   localparam int POS_W  = 38;
   localparam int DIF_W  = POS_W + 1;
   localparam int MAG_W  = 38;
   localparam int SUM_W  = 2 * MAG_W + 2;
   localparam int ROOT_W = SUM_W / 2;
   localparam int DIST_W = ROOT_W + 1;

   localparam logic [0:0] OP_LOAD = 1'b0;
   localparam logic [0:0] OP_EVAL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MESH_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MESH_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MESH_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = 3'd3;

   localparam logic [MESH_W-1:0] MESH_RESET = 24'd65536;

   localparam logic signed [DIST_W-1:0] FAR_Q17 = 40'sd1310720000;

   typedef struct packed {
      logic [0:0]                operation;
      logic [3:0]                sphere_slot;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [RAD_W-1:0]          sphere_radius;
      logic [CELL_W-1:0]         cell_i;
      logic [CELL_W-1:0]         cell_j;
      logic [CELL_W-1:0]         cell_k;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] signed_distance;
      logic               saturated;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [RAD_W-1:0]          sphere_radius;
   } sphere_type;

endpackage

>>> design/sud_table.sv
module sud_table #(
   parameter int MAX_SPHERES = 16,
   parameter int IDX_W = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  sud_pkg::sphere_type  wr_data,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output sud_pkg::sphere_type  rd_data
);
   import sud_pkg::*;

   sphere_type mem [MAX_SPHERES];
   sphere_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sud_sumsq.sv
module sud_sumsq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [sud_pkg::MAG_W-1:0] mag_x,
   input  logic [sud_pkg::MAG_W-1:0] mag_y,
   input  logic [sud_pkg::MAG_W-1:0] mag_z,
   output logic                      done,
   output logic [sud_pkg::SUM_W-1:0] sum
);
   import sud_pkg::*;

   localparam int HALF_W = MAG_W / 2;
   localparam int PROD_W = 2 * HALF_W;

   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_Z = 2'd2;

   localparam logic [1:0] TERM_HH = 2'd0;
   localparam logic [1:0] TERM_HL = 2'd1;
   localparam logic [1:0] TERM_LL = 2'd2;

   logic              issue_ff;
   logic              pv_ff;
   logic              plast_ff;
   logic              done_ff;
   logic [1:0]        axis_ff;
   logic [1:0]        term_ff;
   logic [1:0]        pterm_ff;
   logic [MAG_W-1:0]  magx_ff;
   logic [MAG_W-1:0]  magy_ff;
   logic [MAG_W-1:0]  magz_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [SUM_W-1:0]  acc_ff;
   logic [SUM_W-1:0]  addend;
   logic [MAG_W-1:0]  m;
   logic [HALF_W-1:0] opa;
   logic [HALF_W-1:0] opb;
   logic              last;

   always_comb begin
      case (axis_ff)
         AX_X: begin
            m = magx_ff;
         end
         AX_Y: begin
            m = magy_ff;
         end
         default: begin
            m = magz_ff;
         end
      endcase
      opa = (term_ff == TERM_LL) ? m[HALF_W-1:0] : m[MAG_W-1 -: HALF_W];
      opb = (term_ff == TERM_HH) ? m[MAG_W-1 -: HALF_W] : m[HALF_W-1:0];
      prod_in = PROD_W'(opa) * PROD_W'(opb);
      last = (axis_ff == AX_Z) && (term_ff == TERM_LL);
   end

   always_comb begin
      case (pterm_ff)
         TERM_HH: begin
            addend = SUM_W'(prod_ff) << (2 * HALF_W);
         end
         TERM_HL: begin
            addend = SUM_W'(prod_ff) << (HALF_W + 1);
         end
         default: begin
            addend = SUM_W'(prod_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         pv_ff    <= 1'b0;
         plast_ff <= 1'b0;
         done_ff  <= 1'b0;
         axis_ff  <= AX_X;
         term_ff  <= TERM_HH;
         pterm_ff <= TERM_HH;
      end else begin
         done_ff  <= pv_ff && plast_ff;
         pv_ff    <= issue_ff && !start;
         plast_ff <= last;
         pterm_ff <= term_ff;
         if (start) begin
            issue_ff <= 1'b1;
            axis_ff  <= AX_X;
            term_ff  <= TERM_HH;
         end else if (issue_ff) begin
            if (last) begin
               issue_ff <= 1'b0;
            end
            case (term_ff)
               TERM_HH: begin
                  term_ff <= TERM_HL;
               end
               TERM_HL: begin
                  term_ff <= TERM_LL;
               end
               default: begin
                  term_ff <= TERM_HH;
                  axis_ff <= axis_ff + 2'd1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         magx_ff <= mag_x;
         magy_ff <= mag_y;
         magz_ff <= mag_z;
         acc_ff  <= '0;
      end else if (pv_ff) begin
         acc_ff <= acc_ff + addend;
      end
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

>>> design/sud_sqrt.sv
module sud_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sud_pkg::SUM_W-1:0]  radicand,
   output logic                       done,
   output logic [sud_pkg::ROOT_W-1:0] root
);
   import sud_pkg::*;

   localparam int REM_W  = ROOT_W + 2;
   localparam int STEP_W = $clog2(ROOT_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [SUM_W-1:0]  rad_ff;
   logic [REM_W+1:0]  ext;
   logic [REM_W+1:0]  tst;
   logic [REM_W+1:0]  diff;
   logic              ge;
   logic              last;

   always_comb begin
      ext  = {rem_ff, rad_ff[SUM_W-1 -: 2]};
      tst  = (REM_W + 2)'({root_ff, 2'b01});
      ge   = ext >= tst;
      diff = ge ? (ext - tst) : ext;
      last = cnt_ff == STEP_W'(ROOT_W - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + STEP_W'(1);
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         root_ff <= '0;
         rad_ff  <= radicand;
      end else if (busy_ff) begin
         rem_ff  <= diff[REM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], ge};
         rad_ff  <= rad_ff << 2;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

   // partial remainder never exceeds twice the partial root
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (REM_W'(rem_ff) <= REM_W'({root_ff, 1'b0})))
      else $error("sqrt remainder out of bound");

endmodule

>>> design/sphere_union_signed_distance_unit.sv
// channel  direction  word type      handshake
// req      in         req_word_type  req_valid, req_stall
// rsp      out        rsp_word_type  rsp_valid, rsp_stall
// csr      in         index, data    csr_write
//
// a load word gives no result; an evaluate word runs, for each active sphere, one
// table read, nine 19x19 partial products and a 39-step bit-serial square root
// reset clears control state and the count and presets the mesh; the sphere table holds garbage until loaded
// req_stall is high while an evaluation runs; rsp_stall holds the result register,
// and a finished evaluation waits for it before the next word is taken
module sphere_union_signed_distance_unit #(
   parameter int MAX_SPHERES = sud_pkg::SPHERES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sud_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sud_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_write,
   input  logic [sud_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sud_pkg::MESH_W-1:0]    csr_data
);
   import sud_pkg::*;

   localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int CNT_W = $clog2(MAX_SPHERES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_POINT = 3'd1;
   localparam logic [2:0] ST_NEXT  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_SUMSQ = 3'd4;
   localparam logic [2:0] ST_ROOT  = 3'd5;
   localparam logic [2:0] ST_PICK  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   function automatic logic [DIST_W-1:0] dmag(input logic signed [DIST_W-1:0] v);
      dmag = v[DIST_W-1] ? DIST_W'(-v) : DIST_W'(v);
   endfunction

   function automatic logic [MAG_W-1:0] pmag(input logic signed [DIF_W-1:0] v);
      logic signed [DIF_W-1:0] a;
      a = v[DIF_W-1] ? -v : v;
      pmag = a[MAG_W-1:0];
   endfunction

   logic [2:0]               state_ff, state_in;
   logic [MESH_W-1:0]        mesh_x_ff, mesh_y_ff, mesh_z_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic [CELL_W-1:0]        ci_ff, cj_ff, ck_ff;
   logic signed [POS_W-1:0]  px_ff, py_ff, pz_ff;
   logic signed [POS_W-1:0]  px_in, py_in, pz_in;
   logic [CNT_W-1:0]         s_ff;
   logic [CNT_W-1:0]         lim;
   logic signed [DIST_W-1:0] best_ff;
   logic signed [DIST_W-1:0] d_in;
   logic                     rsp_valid_ff;
   rsp_word_type             rsp_word_ff;
   rsp_word_type             rsp_in;

   logic                     req_accept;
   logic                     tbl_wr;
   logic                     tbl_rd;
   logic [31:0]              slot_wide;
   sphere_type               tbl_wdata;
   sphere_type               tbl_rdata;

   logic                     sq_start, sq_done;
   logic [SUM_W-1:0]         sq_sum;
   logic                     rt_start, rt_done;
   logic [ROOT_W-1:0]        rt_root;
   logic [MAG_W-1:0]         mx, my, mz;

   logic signed [DIST_W:0]   q;
   logic signed [DIST_W:0]   res;
   logic                     fits;
   logic                     out_free;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign slot_wide = 32'(req_word.sphere_slot);
   assign tbl_wr    = req_accept && (req_word.operation == OP_LOAD)
                      && (slot_wide < 32'(MAX_SPHERES));
   assign tbl_wdata = '{center_x: req_word.center_x, center_y: req_word.center_y,
                        center_z: req_word.center_z,
                        sphere_radius: req_word.sphere_radius};
   assign tbl_rd    = (state_ff == ST_NEXT) && (s_ff != lim);

   assign lim = (32'(count_ff) > 32'(MAX_SPHERES)) ? CNT_W'(MAX_SPHERES)
                                                   : CNT_W'(count_ff);

   always_comb begin
      px_in = POS_W'($signed({1'b0, ci_ff, 1'b0}) - 13'sd1)
              * POS_W'($signed({1'b0, mesh_x_ff}));
      py_in = POS_W'($signed({1'b0, cj_ff, 1'b0}) - 13'sd1)
              * POS_W'($signed({1'b0, mesh_y_ff}));
      pz_in = POS_W'($signed({1'b0, ck_ff, 1'b0}) - 13'sd1)
              * POS_W'($signed({1'b0, mesh_z_ff}));
   end

   always_comb begin
      mx = pmag(DIF_W'(px_ff) - (DIF_W'(tbl_rdata.center_x) <<< 1));
      my = pmag(DIF_W'(py_ff) - (DIF_W'(tbl_rdata.center_y) <<< 1));
      mz = pmag(DIF_W'(pz_ff) - (DIF_W'(tbl_rdata.center_z) <<< 1));
      d_in = $signed({1'b0, rt_root})
             - $signed({{(DIST_W - RAD_W - 1){1'b0}}, tbl_rdata.sphere_radius, 1'b0});
   end

   assign sq_start = state_ff == ST_READ;
   assign rt_start = (state_ff == ST_SUMSQ) && sq_done;

   always_comb begin
      q    = (DIST_W + 1)'(best_ff) + (DIST_W + 1)'(1);
      res  = q >>> 1;
      fits = (res[DIST_W:31] == '0) || (res[DIST_W:31] == '1);
      rsp_in.saturated = !fits;
      if (fits) begin
         rsp_in.signed_distance = res[31:0];
      end else if (res[DIST_W]) begin
         rsp_in.signed_distance = 32'sh8000_0000;
      end else begin
         rsp_in.signed_distance = 32'sh7fff_ffff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_word.operation == OP_EVAL)) begin
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = (s_ff == lim) ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            state_in = ST_SUMSQ;
         end
         ST_SUMSQ: begin
            if (sq_done) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rt_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = ST_NEXT;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mesh_x_ff    <= MESH_RESET;
         mesh_y_ff    <= MESH_RESET;
         mesh_z_ff    <= MESH_RESET;
         count_ff     <= '0;
         s_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_POINT) begin
            s_ff <= '0;
         end else if (state_ff == ST_PICK) begin
            s_ff <= s_ff + CNT_W'(1);
         end
         if (csr_write) begin
            case (csr_index)
               CSR_MESH_X: begin
                  mesh_x_ff <= csr_data;
               end
               CSR_MESH_Y: begin
                  mesh_y_ff <= csr_data;
               end
               CSR_MESH_Z: begin
                  mesh_z_ff <= csr_data;
               end
               CSR_COUNT: begin
                  count_ff <= csr_data[COUNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ci_ff <= req_word.cell_i;
         cj_ff <= req_word.cell_j;
         ck_ff <= req_word.cell_k;
      end
      if (state_ff == ST_POINT) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         pz_ff   <= pz_in;
         best_ff <= FAR_Q17;
      end else if ((state_ff == ST_PICK) && (dmag(d_in) < dmag(best_ff))) begin
         best_ff <= d_in;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_word_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   sud_table #(
      .MAX_SPHERES (MAX_SPHERES),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (slot_wide[IDX_W-1:0]),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_rd),
      .rd_addr (s_ff[IDX_W-1:0]),
      .rd_data (tbl_rdata)
   );

   sud_sumsq u_sumsq (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .mag_x (mx),
      .mag_y (my),
      .mag_z (mz),
      .done  (sq_done),
      .sum   (sq_sum)
   );

   sud_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (sq_sum),
      .done     (rt_done),
      .root     (rt_root)
   );

   // best distance starts at the far value and only ever shrinks
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT) |-> (dmag(best_ff) <= DIST_W'(FAR_Q17)))
      else $error("best distance above start value");

   // sphere index never runs past the active count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT) |-> (32'(s_ff) <= 32'(lim)))
      else $error("sphere index past active count");

   // a result never clips, the start value bounds it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !rsp_word_ff.saturated)
      else $error("result saturated");

endmodule

>>> tb/tb_sphere_union_signed_distance_unit.sv
`timescale 1ns / 1ps

module tb_sphere_union_signed_distance_unit;
   import sud_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int DRAIN_CYCLES = 1000;
   localparam int RANDOM_PHASES = 22;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SPARE = 3'd4;
   localparam longint FAR_DISTANCE = 64'sd1310720000;
   localparam logic [RAD_W-1:0] RADIUS_ONE = 31'd65536;
   localparam logic [RAD_W-1:0] RADIUS_FAR = 31'd655360000;
   localparam logic signed [COORD_W-1:0] HALF = 32'sd32768;
   localparam logic signed [COORD_W-1:0] TWO_AND_HALF = 32'sd163840;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MESH_W-1:0] csr_data = '0;

   sphere_type sphere_table [TABLE_DEPTH];
   logic [MESH_W-1:0] mesh_x = MESH_RESET;
   logic [MESH_W-1:0] mesh_y = MESH_RESET;
   logic [MESH_W-1:0] mesh_z = MESH_RESET;
   logic [COUNT_W-1:0] active_count = '0;
   rsp_word_type pending_distances [$];
   int mismatches = 0;
   int send_idle_pct = 33;
   int stall_pct = 33;
   logic receiver_hold = 1'b0;

   sphere_union_signed_distance_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= receiver_hold || ($urandom_range(99) < stall_pct);
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 100) $display("%0t mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_distances.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %h", rsp_word));
         end else begin
            want = pending_distances.pop_front();
            if (rsp_word.signed_distance !== want.signed_distance)
               report_mismatch($sformatf("signed_distance %0d, wanted %0d",
                  rsp_word.signed_distance, want.signed_distance));
            if (rsp_word.saturated !== want.saturated)
               report_mismatch($sformatf("saturated %b, wanted %b",
                  rsp_word.saturated, want.saturated));
         end
      end
   end

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic rsp_word_type nearest_distance(input req_word_type w);
      longint point [3];
      longint centre [3];
      longint gap, best, rounded, spheres;
      logic [127:0] sum, trial;
      logic [63:0] root;
      rsp_word_type r;
      point[0] = (2 * longint'(w.cell_i) - 1) * longint'(mesh_x);
      point[1] = (2 * longint'(w.cell_j) - 1) * longint'(mesh_y);
      point[2] = (2 * longint'(w.cell_k) - 1) * longint'(mesh_z);
      best = FAR_DISTANCE;
      spheres = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
      for (int s = 0; s < spheres; s++) begin
         centre[0] = longint'(sphere_table[s].center_x);
         centre[1] = longint'(sphere_table[s].center_y);
         centre[2] = longint'(sphere_table[s].center_z);
         sum = '0;
         for (int a = 0; a < 3; a++) begin
            trial = 128'(magnitude(point[a] - 2 * centre[a]));
            sum += trial * trial;
         end
         root = '0;
         for (int b = 40; b >= 0; b--) begin
            trial = 128'(root | (64'd1 << b));
            if (trial * trial <= sum) root = trial[63:0];
         end
         gap = longint'(root) - 2 * longint'(sphere_table[s].sphere_radius);
         // ties keep the earlier candidate
         if (magnitude(gap) < magnitude(best)) best = gap;
      end
      rounded = (best + 1) >>> 1;
      r.saturated = (rounded > 64'sd2147483647) || (rounded < -64'sd2147483648);
      if (rounded > 64'sd2147483647) r.signed_distance = 32'sh7fffffff;
      else if (rounded < -64'sd2147483648) r.signed_distance = 32'sh80000000;
      else r.signed_distance = rounded[31:0];
      return r;
   endfunction

   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      if (w.operation == OP_EVAL) begin
         pending_distances.push_back(nearest_distance(w));
      end else begin
         sphere_table[w.sphere_slot].center_x = w.center_x;
         sphere_table[w.sphere_slot].center_y = w.center_y;
         sphere_table[w.sphere_slot].center_z = w.center_z;
         sphere_table[w.sphere_slot].sphere_radius = w.sphere_radius;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [MESH_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_MESH_X: mesh_x = value;
         CSR_MESH_Y: mesh_y = value;
         CSR_MESH_Z: mesh_z = value;
         CSR_COUNT: active_count = value[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [MESH_W-1:0] mx, input logic [MESH_W-1:0] my,
                            input logic [MESH_W-1:0] mz, input logic [MESH_W-1:0] count);
      settle();
      write_register(CSR_MESH_X, mx);
      write_register(CSR_MESH_Y, my);
      write_register(CSR_MESH_Z, mz);
      write_register(CSR_COUNT, count);
      // unused index, must be ignored
      write_register(CSR_FIRST_SPARE + 3'($urandom_range(3)), 24'($urandom));
      csr_write <= 1'b0;
   endtask

   function automatic logic [COORD_W-1:0] near_coord();
      return 32'(int'($urandom_range(1 << 27)) - (1 << 26));
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      w.operation = 1'($urandom);
      w.sphere_slot = 4'($urandom);
      w.center_x = $urandom;
      w.center_y = $urandom;
      w.center_z = $urandom;
      w.sphere_radius = 31'($urandom);
      w.cell_i = 11'($urandom);
      w.cell_j = 11'($urandom);
      w.cell_k = 11'($urandom);
      return w;
   endfunction

   function automatic req_word_type eval_word(input logic [CELL_W-1:0] ci,
                                              input logic [CELL_W-1:0] cj,
                                              input logic [CELL_W-1:0] ck);
      req_word_type w;
      w = random_word();
      w.operation = OP_EVAL;
      w.cell_i = ci;
      w.cell_j = cj;
      w.cell_k = ck;
      return w;
   endfunction

   function automatic req_word_type load_word(input logic [3:0] slot,
                                              input logic signed [COORD_W-1:0] cx,
                                              input logic signed [COORD_W-1:0] cy,
                                              input logic signed [COORD_W-1:0] cz,
                                              input logic [RAD_W-1:0] radius);
      req_word_type w;
      w = random_word();
      w.operation = OP_LOAD;
      w.sphere_slot = slot;
      w.center_x = cx;
      w.center_y = cy;
      w.center_z = cz;
      w.sphere_radius = radius;
      return w;
   endfunction

   function automatic req_word_type random_load();
      req_word_type w;
      w = random_word();
      w.operation = OP_LOAD;
      if ($urandom_range(9) < 7) begin
         w.center_x = near_coord();
         w.center_y = near_coord();
         w.center_z = near_coord();
         w.sphere_radius = 31'($urandom_range(1 << 26));
      end
      return w;
   endfunction

   function automatic req_word_type random_eval();
      req_word_type w;
      w = random_word();
      w.operation = OP_EVAL;
      if ($urandom_range(19) != 0) begin
         w.cell_i = 11'($urandom_range(1025));
         w.cell_j = 11'($urandom_range(1025));
         w.cell_k = 11'($urandom_range(1025));
      end
      return w;
   endfunction

   function automatic logic [MESH_W-1:0] pick_mesh();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 24'($urandom);
         default: return 24'($urandom_range(8192, 196608));
      endcase
   endfunction

   // mostly few spheres, now and then the full table or more
   function automatic logic [MESH_W-1:0] pick_count();
      logic [COUNT_W-1:0] n;
      int r;
      r = $urandom_range(19);
      if (r < 12) n = 5'($urandom_range(4));
      else if (r < 16) n = 5'($urandom_range(5, 15));
      else if (r < 18) n = 5'(TABLE_DEPTH);
      else n = 5'($urandom_range(17, 31));
      return {19'($urandom), n};
   endfunction

   task automatic random_phase(input int items);
      configure(pick_mesh(), pick_mesh(), pick_mesh(), pick_count());
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(99) < 40) send_word(random_load());
         else send_word(random_eval());
      end
   endtask

   task automatic test_reset_values();
      send_word(eval_word(11'd0, 11'd0, 11'd0));
      send_word(eval_word('1, '1, '1));
   endtask

   task automatic test_table_extremes();
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         case (s % 4)
            0: send_word(load_word(4'(s), 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, '1));
            1: send_word(load_word(4'(s), 32'sh80000000, 32'sh80000000, 32'sh80000000, '0));
            2: send_word(load_word(4'(s), '0, '0, '0, RADIUS_ONE));
            default: send_word(load_word(4'(s), near_coord(), near_coord(), near_coord(),
                                         31'($urandom_range(1 << 26))));
         endcase
      end
      configure('1, '1, '1, 24'(TABLE_DEPTH));
      send_word(eval_word(11'd1025, 11'd0, '1));
      send_word(eval_word(11'd1, 11'd1, 11'd1));
      // count above the table size
      configure('0, '0, '0, 24'hffffff);
      send_word(eval_word(11'd513, 11'd513, 11'd513));
   endtask

   task automatic test_nearest_ties();
      configure(MESH_RESET, MESH_RESET, MESH_RESET, 24'd3);
      // first entry ties the start value, second and third tie each other
      send_word(load_word(4'd0, HALF, HALF, HALF, RADIUS_FAR));
      send_word(load_word(4'd1, HALF, HALF, HALF, RADIUS_ONE));
      send_word(load_word(4'd2, TWO_AND_HALF, HALF, HALF, RADIUS_ONE));
      send_word(eval_word(11'd1, 11'd1, 11'd1));
      configure(MESH_RESET, MESH_RESET, MESH_RESET, 24'd1);
      send_word(eval_word(11'd1, 11'd1, 11'd1));
      configure(MESH_RESET, MESH_RESET, MESH_RESET, 24'd3);
      send_word(load_word(4'd1, TWO_AND_HALF, HALF, HALF, RADIUS_ONE));
      send_word(load_word(4'd2, HALF, HALF, HALF, RADIUS_ONE));
      send_word(eval_word(11'd1, 11'd1, 11'd1));
   endtask

   task automatic test_back_to_back();
      send_idle_pct = 0;
      stall_pct = 0;
      random_phase(100);
      settle();
      send_idle_pct = 33;
      stall_pct = 33;
   endtask

   task automatic hold_receiver(input int cycles);
      receiver_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      receiver_hold <= 1'b0;
   endtask

   task automatic test_receiver_hold();
      configure(MESH_RESET, MESH_RESET, MESH_RESET, 24'd2);
      send_idle_pct = 0;
      fork
         hold_receiver(3000);
         for (int n = 0; n < 30; n++) send_word(random_eval());
      join
      send_idle_pct = 33;
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < RANDOM_PHASES; p++) random_phase(50);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_table_extremes();
      test_nearest_ties();
      test_back_to_back();
      test_receiver_hold();
      test_random_traffic();
      settle();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
